// ===== rtl/address_slot_table_oldest_evict_assert.svh =====
// Assertion macros for the checker module in aste_check.sv.
`ifndef ADDRESS_SLOT_TABLE_OLDEST_EVICT_ASSERT_SVH
`define ADDRESS_SLOT_TABLE_OLDEST_EVICT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ASTE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASTE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/aste_pkg.sv =====
`default_nettype none

package aste_pkg;

  // Fixed field widths
  localparam int ADDR_W    = 48;
  localparam int TIME_W    = 32;
  localparam int SLOT_OUT_W = 3;
  localparam int OUTCOME_W = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Outcome codes
  localparam logic [OUTCOME_W-1:0] OUTCOME_MATCH = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_EMPTY = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] device_address;
    logic [TIME_W-1:0] seen_time;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [OUTCOME_W-1:0]  outcome;
    logic [ADDR_W-1:0]     evicted_address;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic read;
    logic eval;
    logic write;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/aste_ctrl.sv =====
`default_nettype none

module aste_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire aste_pkg::status_t status,
  output aste_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 done
);
  import aste_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t state, state_next;

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_WRITE);
    end
  end

  // On start load the item, then sequence one read and one evaluation per slot, then write
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.last ? S_WRITE : S_READ;
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/aste_dp.sv =====
`default_nettype none

module aste_dp #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire aste_pkg::in_item_t item,
  input  wire aste_pkg::cmd_t     cmd,
  output aste_pkg::status_t       status,
  output aste_pkg::out_item_t     result
);
  import aste_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);

  // Table storage; valid bits give the reset view of empty slots
  logic [ADDR_W-1:0]     addr_mem [SLOT_COUNT];
  logic [TIME_W-1:0]     time_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid;

  in_item_t          in_reg;
  logic [SLOT_W-1:0] idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [TIME_W-1:0] rd_time;
  logic              rd_valid;

  logic              match_found;
  logic              empty_found;
  logic [SLOT_W-1:0] match_idx;
  logic [SLOT_W-1:0] empty_idx;
  logic [SLOT_W-1:0] best_idx;
  logic [TIME_W-1:0] best_time;
  logic [ADDR_W-1:0] best_addr;

  logic [ADDR_W-1:0]    eff_addr;
  logic [TIME_W-1:0]    eff_time;
  logic [SLOT_W-1:0]    chosen;
  logic [OUTCOME_W-1:0] outcome;

  // Slot view with never-written entries reading as zero
  assign eff_addr = rd_valid ? rd_addr : '0;
  assign eff_time = rd_valid ? rd_time : '0;

  assign status.last = (idx == SLOT_W'(SLOT_COUNT - 1));

  // Pick the slot: match, else empty, else oldest
  always_comb begin
    if (match_found) begin
      chosen  = match_idx;
      outcome = OUTCOME_MATCH;
    end else if (empty_found) begin
      chosen  = empty_idx;
      outcome = OUTCOME_EMPTY;
    end else begin
      chosen  = best_idx;
      outcome = OUTCOME_EVICT;
    end
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      addr_mem[chosen] <= in_reg.device_address;
      time_mem[chosen] <= in_reg.seen_time;
    end
    if (cmd.read) begin
      rd_addr  <= addr_mem[idx];
      rd_time  <= time_mem[idx];
      rd_valid <= slot_valid[idx];
    end
  end

  // Valid bits and scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      idx        <= '0;
    end else begin
      if (cmd.write) begin
        slot_valid[chosen] <= 1'b1;
      end
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.eval && !status.last) begin
        idx <= idx + SLOT_W'(1);
      end
    end
  end

  // Hold the item and track the search over slots
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_reg      <= item;
      match_found <= 1'b0;
      empty_found <= 1'b0;
    end else if (cmd.eval) begin
      if (!match_found && (eff_addr == in_reg.device_address)) begin
        match_found <= 1'b1;
        match_idx   <= idx;
      end
      if (!empty_found && (eff_addr[ADDR_W-1 -: 8] == 8'd0)) begin
        empty_found <= 1'b1;
        empty_idx   <= idx;
      end
      // First slot seeds the minimum; later ones replace it only when strictly older
      if ((idx == '0) || (eff_time < best_time)) begin
        best_time <= eff_time;
        best_idx  <= idx;
        best_addr <= eff_addr;
      end
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      result.slot_index      <= SLOT_OUT_W'(chosen);
      result.outcome         <= outcome;
      result.evicted_address <= (outcome == OUTCOME_EVICT) ? best_addr : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/address_slot_table_oldest_evict.sv =====
`default_nettype none

// Address slot table with oldest-entry eviction.
//
// Input: drive item (address and time) with start; the beat is taken at a
// clock edge where start is high and busy is low. busy stays high while the
// item is worked on.
// Output: one result beat per item, on result for exactly one cycle with
// done high. The receiver cannot stall; the beat must be taken then.
// The block scans the table one slot at a time through a single-port table
// read, a read state and an evaluate state per slot, then writes the chosen
// slot. A new item is not taken before the block is back in idle.
// The next item may be accepted in the same cycle that done is shown.
// Reset (rst, synchronous) clears the per-slot valid bits, so every slot
// reads as empty with a zero time at once; no clearing pass is run.
// slot_index carries the low three bits of the chosen slot number.
module address_slot_table_oldest_evict #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire aste_pkg::in_item_t item,
  output logic                    busy,
  output logic                    done,
  output aste_pkg::out_item_t     result
);
  import aste_pkg::*;

  cmd_t    cmd;
  status_t status;

  aste_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  aste_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

`default_nettype wire

// ===== rtl/aste_check.sv =====
`default_nettype none

`include "address_slot_table_oldest_evict_assert.svh"

module aste_check (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire aste_pkg::out_item_t result
);
  import aste_pkg::*;

  logic quiet_beat;
  logic quiet_fields_ok;

  // Result beat that is not an eviction, and what its fields must show
  assign quiet_beat      = done && (result.outcome != OUTCOME_EVICT);
  assign quiet_fields_ok = (result.evicted_address == '0) &&
                           ((result.outcome == OUTCOME_MATCH) ||
                            (result.outcome == OUTCOME_EMPTY));

  // Accepted beat starts work
  `ASTE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "busy not raised after accept")

  // Result only follows work in progress
  `ASTE_ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy), "result without work")

  // done is never high on consecutive cycles
  `ASTE_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result shown twice")

  // Evicted address only on eviction, outcome code in range
  `ASTE_ASSERT_NOW(a_evict_zero, clk, rst, quiet_beat, quiet_fields_ok, "bad outcome or evicted")

endmodule

bind address_slot_table_oldest_evict aste_check u_check (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// ===== dv/address_slot_table_oldest_evict_tb.sv =====
`timescale 1ns / 100ps

module address_slot_table_oldest_evict_tb;
  import aste_pkg::*;

  localparam int SLOTS        = 8;
  localparam int RANDOM_BEATS = 1600;
  localparam int POOL_SIZE    = 12;
  localparam int CALM_TAIL    = 200;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  in_item_t  item  = '0;
  logic      busy;
  logic      done;
  out_item_t result;

  // Detections waiting to be sent, and slot placements still due back
  in_item_t  pending_beats[$];
  out_item_t placements_due[$];

  // Shadow copy of the slot table
  logic [ADDR_W-1:0] shadow_addr [SLOTS];
  logic [TIME_W-1:0] shadow_time [SLOTS];

  logic took_beat   = 1'b0;
  int   gap_left    = 0;
  int   beats_sent  = 0;
  int   error_count = 0;
  int   match_count = 0;
  int   empty_count = 0;
  int   evict_count = 0;

  always #5 clk = ~clk;

  address_slot_table_oldest_evict #(
    .SLOT_COUNT(SLOTS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  function automatic in_item_t detection(logic [ADDR_W-1:0] addr, logic [TIME_W-1:0] when);
    in_item_t b;
    b.device_address = addr;
    b.seen_time      = when;
    return b;
  endfunction

  function automatic logic [ADDR_W-1:0] any_addr();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // Address with a nonzero first byte, so it occupies its slot
  function automatic logic [ADDR_W-1:0] fresh_addr();
    return {8'($urandom_range(1, 255)), 40'({$urandom(), $urandom()})};
  endfunction

  // Choose a slot for one detection, update the shadow table, return the placement
  function automatic out_item_t place_address(in_item_t beat);
    out_item_t         placed;
    int                pick;
    bit                found;
    logic [TIME_W-1:0] oldest;
    placed = '0;
    pick   = 0;
    found  = 1'b0;
    // exact match wins first, even on a slot that reads as empty
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && shadow_addr[i] == beat.device_address) begin
        pick           = i;
        found          = 1'b1;
        placed.outcome = OUTCOME_MATCH;
      end
    end
    // then the lowest slot whose first byte is zero
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && shadow_addr[i][ADDR_W-1 -: 8] == 8'h00) begin
        pick           = i;
        found          = 1'b1;
        placed.outcome = OUTCOME_EMPTY;
      end
    end
    // else the strictly oldest time; lowest index holds on ties
    if (!found) begin
      oldest = TIME_MAX;
      for (int i = 0; i < SLOTS; i++) begin
        if (shadow_time[i] < oldest) begin
          oldest = shadow_time[i];
          pick   = i;
        end
      end
      placed.outcome         = OUTCOME_EVICT;
      placed.evicted_address = shadow_addr[pick];
    end
    placed.slot_index = pick[SLOT_OUT_W-1:0];
    shadow_addr[pick] = beat.device_address;
    shadow_time[pick] = beat.seen_time;
    return placed;
  endfunction

  // Driver: present the head of the queue at the falling edge, with idle bursts
  always @(negedge clk) begin
    bit idle_ok;
    idle_ok = 1'b0;
    if (!rst) begin
      // drop the beat taken at the last rising edge
      if (took_beat && pending_beats.size() != 0) begin
        void'(pending_beats.pop_front());
        beats_sent++;
      end
      idle_ok = pending_beats.size() > CALM_TAIL && ((beats_sent / 150) % 2 == 0);
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_beats.size() == 0) begin
        start <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 2);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        item  <= pending_beats[0];
      end
    end
  end

  // Monitor: check result beats, then predict for any beat taken at this edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      took_beat <= 1'b0;
    end else begin
      if (done === 1'b1) begin
        if (placements_due.size() == 0) begin
          $error("result beat with nothing due: slot_index %0d outcome %0d",
                 result.slot_index, result.outcome);
          error_count++;
        end else begin
          want = placements_due.pop_front();
          if (result.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, result.slot_index);
            error_count++;
          end
          if (result.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, result.outcome);
            error_count++;
          end
          if (result.evicted_address !== want.evicted_address) begin
            $error("evicted_address: expected %h, got %h",
                   want.evicted_address, result.evicted_address);
            error_count++;
          end
        end
      end
      took_beat <= start && !busy;
      if (start && !busy) begin
        want = place_address(item);
        placements_due.push_back(want);
        case (want.outcome)
          OUTCOME_MATCH: match_count++;
          OUTCOME_EMPTY: empty_count++;
          default:       evict_count++;
        endcase
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [ADDR_W-1:0] pool [POOL_SIZE];
    logic [TIME_W-1:0] clock_ms;
    int                pick;
    int                roll;

    for (int i = 0; i < SLOTS; i++) begin
      shadow_addr[i] = '0;
      shadow_time[i] = '0;
    end

    // all-zero address matches the cleared slot 0
    pending_beats.push_back(detection('0, '0));
    // first byte zero with low bits set: stored, slot still empty
    pending_beats.push_back(detection(48'h00FF_FFFF_FFFF, 32'd5));
    // empty slot with leftover bits is taken quietly
    pending_beats.push_back(detection('1, TIME_MAX));
    // fill the rest with maximum times
    for (int i = 1; i < SLOTS; i++) begin
      pending_beats.push_back(detection({8'(i * 8'h21), 40'(i)}, TIME_MAX));
    end
    // all times at the maximum: slot 0 goes
    pending_beats.push_back(detection(48'h1234_5678_9ABC, 32'd100));
    // refresh slot 3 to tie with slot 0
    pending_beats.push_back(detection({8'h63, 40'd3}, 32'd100));
    // tie: lowest index evicted, then the other
    pending_beats.push_back(detection(48'h8000_0000_0000, 32'd200));
    pending_beats.push_back(detection(48'h7FFF_FFFF_FFFF, '0));
    pending_beats.push_back(detection(48'h0100_0000_0001, 32'd300));
    // first byte zero on a full table evicts, leaving that slot empty
    pending_beats.push_back(detection(48'h0012_3456_789A, 32'd400));
    pending_beats.push_back(detection(48'hA5A5_A5A5_A5A5, 32'd500));
    pending_beats.push_back(detection(48'h0012_3456_789A, 32'd600));
    pending_beats.push_back(detection(48'h5A5A_5A5A_5A5A, TIME_MAX));
    pending_beats.push_back(detection('0, 32'd700));
    pending_beats.push_back(detection(48'hA5A5_A5A5_A5A5, TIME_MAX));

    // random part: a working set of sources with mostly rising times
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = fresh_addr();
    end
    clock_ms = $urandom_range(0, 1000);
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 19) == 0) begin
        pool[pick] = fresh_addr();
      end
      clock_ms += $urandom_range(0, 40);
      if (roll < 70) begin
        pending_beats.push_back(detection(pool[pick], clock_ms));
      end else if (roll < 80) begin
        pending_beats.push_back(detection(pool[pick], $urandom()));
      end else if (roll < 85) begin
        pending_beats.push_back(detection(pool[pick], $urandom_range(0, 1) ? TIME_MAX : '0));
      end else if (roll < 93) begin
        pending_beats.push_back(detection(any_addr(), $urandom()));
      end else if (roll < 97) begin
        pending_beats.push_back(detection({8'h00, pool[pick][39:0]}, clock_ms));
      end else begin
        pending_beats.push_back(detection('0, clock_ms));
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || placements_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (2 * SLOTS + 8) @(posedge clk);

    $display("sent %0d detections through a %0d-slot table", beats_sent, SLOTS);
    $display("placements: %0d matched, %0d into empty slots, %0d evictions",
             match_count, empty_count, evict_count);
    if (error_count == 0) begin
      $display("address_slot_table_oldest_evict_tb: clean");
    end else begin
      $display("address_slot_table_oldest_evict_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $error("timed out: %0d beats unsent, %0d results due",
           pending_beats.size(), placements_due.size());
    $display("address_slot_table_oldest_evict_tb: errors");
    $finish;
  end

endmodule
